// ===== rtl/core/assert_macros.svh =====
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold on every clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition must never be seen outside reset
`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== rtl/core/rde_pkg.sv =====
`timescale 1ns / 1ps

package rde_pkg;

    localparam int VALUE_W  = 63;
    localparam int RADIX_W  = 5;
    localparam int DIGIT_W  = 4;
    localparam int SYM_W    = 8;
    localparam int POS_W    = 7;
    localparam int CNT_W    = 6;
    localparam int CFG_W    = 64;
    localparam int CFG_IDX_W = 2;

    localparam int DEF_MAX_SYMBOLS = 16;
    localparam logic [RADIX_W-1:0] BASE_LEN_RESET = RADIX_W'(10);

    // divider: one 64-bit dividend word, eight quotient bits per cycle
    localparam int DIV_WORD_W         = 64;
    localparam int DIV_BITS_PER_CYCLE = 8;
    localparam int DIV_STEPS          = DIV_WORD_W / DIV_BITS_PER_CYCLE;
    localparam int DIV_STEP_W         = $clog2(DIV_STEPS);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BASE_LEN      = 2'd0,
        REG_ALPHABET_LOW  = 2'd1,
        REG_ALPHABET_HIGH = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               start_pos;
    } item_t;

    typedef struct packed {
        logic [SYM_W-1:0] symbol;
        logic [POS_W-1:0] position;
        logic             last;
    } result_t;

    typedef struct packed {
        logic               start;
        logic [RADIX_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic               done;
        logic [DIGIT_W-1:0] remainder;
    } div_stat_t;

endpackage

// ===== rtl/core/rde_div_unit.sv =====
`timescale 1ns / 1ps

module rde_div_unit
    import rde_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  div_req_t           req,
    input  logic [VALUE_W-1:0] dividend,
    output div_stat_t          stat,
    output logic [VALUE_W-1:0] quotient
);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [DIV_STEP_W-1:0] step_reg, step_next;
    logic [DIV_WORD_W-1:0] work_reg, work_next;
    logic [DIGIT_W-1:0]    part_reg, part_next;
    logic [RADIX_W-1:0]    dvsr_reg, dvsr_next;

    logic [DIV_WORD_W-1:0] shift_w;
    logic [DIGIT_W-1:0]    shift_p;

    // restoring division, eight bits per cycle; partial remainder stays below divisor
    always_comb
    begin
        logic [DIGIT_W:0] trial;
        shift_w = work_reg;
        shift_p = part_reg;
        for (int i = 0; i < DIV_BITS_PER_CYCLE; i++)
        begin
            trial   = {shift_p, shift_w[DIV_WORD_W-1]};
            shift_w = {shift_w[DIV_WORD_W-2:0], 1'b0};
            if (trial >= dvsr_reg)
            begin
                trial      = trial - dvsr_reg;
                shift_w[0] = 1'b1;
            end
            shift_p = trial[DIGIT_W-1:0];
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        work_next = work_reg;
        part_next = part_reg;
        dvsr_next = dvsr_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            work_next = {{(DIV_WORD_W - VALUE_W){1'b0}}, dividend};
            part_next = '0;
            dvsr_next = req.divisor;
        end
        else if (busy_reg)
        begin
            work_next = shift_w;
            part_next = shift_p;
            step_next = step_reg + DIV_STEP_W'(1);
            if (step_reg == DIV_STEP_W'(DIV_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
        part_reg <= part_next;
        dvsr_reg <= dvsr_next;
    end

    assign stat.done      = done_reg;
    assign stat.remainder = part_reg;
    assign quotient       = work_reg[VALUE_W-1:0];

endmodule

// ===== rtl/core/radix_digit_emitter.sv =====
`timescale 1ns / 1ps

// Converts a non-negative 63-bit value into digits of a radix from 2 to 16, using a
// software-loaded symbol alphabet. Each accepted word yields a terminator word (symbol
// zero) at position start_pos plus digit count, then the digit symbols least significant
// first at falling positions; the final word carries last. A zero value gives only the
// terminator. One shared divider does all the work, eight quotient bits per cycle, and
// every digit is divided out twice, once to count and once to emit. The item side stalls
// from acceptance until the final word has been loaded into the output register. The
// radix taken from its register is clamped to 2..MAX_SYMBOLS; the alphabet is emitted
// as loaded.
module radix_digit_emitter
    import rde_pkg::*;
#(
    parameter int MAX_SYMBOLS = DEF_MAX_SYMBOLS
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    // item channel
    input  logic                 item_valid,
    output logic                 item_stall,
    input  item_t                item,
    // result channel
    output logic                 result_valid,
    input  logic                 result_stall,
    output result_t              result,
    // configuration writes
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    localparam logic [RADIX_W-1:0] MAX_RADIX = RADIX_W'(MAX_SYMBOLS);
    localparam logic [RADIX_W-1:0] MIN_RADIX = RADIX_W'(2);

    // sequencer: count digits, emit terminator, then divide and emit each digit
    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_COUNT = 5'b00010,
        S_TERM  = 5'b00100,
        S_DIGIT = 5'b01000,
        S_EMIT  = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    // configuration registers
    logic [RADIX_W-1:0] base_len_reg;
    logic [CFG_W-1:0]   alpha_lo_reg;
    logic [CFG_W-1:0]   alpha_hi_reg;

    // working registers of one conversion
    logic [VALUE_W-1:0] value_reg, value_next;
    logic               start_reg, start_next;
    logic [VALUE_W-1:0] remaining_reg, remaining_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [POS_W-1:0]   write_pos_reg, write_pos_next;
    logic [DIGIT_W-1:0] digit_reg, digit_next;

    // output register
    logic    res_valid_reg, res_valid_next;
    result_t res_word_reg, res_word_next;

    div_req_t           div_req;
    div_stat_t          div_stat;
    logic [VALUE_W-1:0] div_quot;

    logic [RADIX_W-1:0]     radix;
    logic [2*CFG_W-1:0]     alphabet;
    logic [SYM_W-1:0]       digit_sym;
    logic                   out_free;
    logic                   item_take;

    // clamp the radix into the usable range
    always_comb
    begin
        priority if (base_len_reg < MIN_RADIX)
            radix = MIN_RADIX;
        else if (base_len_reg > MAX_RADIX)
            radix = MAX_RADIX;
        else
            radix = base_len_reg;
    end

    assign alphabet  = {alpha_hi_reg, alpha_lo_reg};
    assign digit_sym = alphabet[{digit_reg, 3'b000} +: SYM_W];

    // output slot is free when empty or its word leaves this cycle
    assign out_free  = !res_valid_reg || !result_stall;
    assign item_take = item_valid && (state_reg == S_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        value_next     = value_reg;
        start_next     = start_reg;
        remaining_next = remaining_reg;
        cnt_next       = cnt_reg;
        write_pos_next = write_pos_reg;
        digit_next     = digit_reg;
        res_valid_next = res_valid_reg && result_stall;
        res_word_next  = res_word_reg;
        div_req.start   = 1'b0;
        div_req.divisor = radix;

        unique case (state_reg)
            S_IDLE:
            begin
                if (item_take)
                begin
                    value_next     = item.value;
                    start_next     = item.start_pos;
                    remaining_next = item.value;
                    cnt_next       = '0;
                    if (item.value == '0)
                        state_next = S_TERM;
                    else
                    begin
                        div_req.start = 1'b1;
                        state_next    = S_COUNT;
                    end
                end
            end
            S_COUNT:
            begin
                // counting pass: one digit per division until the quotient is zero
                if (div_stat.done)
                begin
                    cnt_next       = cnt_reg + CNT_W'(1);
                    remaining_next = div_quot;
                    if (div_quot == '0)
                        state_next = S_TERM;
                    else
                        div_req.start = 1'b1;
                end
            end
            S_TERM:
            begin
                if (out_free)
                begin
                    res_valid_next         = 1'b1;
                    res_word_next.symbol   = '0;
                    res_word_next.position = POS_W'(start_reg) + POS_W'(cnt_reg);
                    res_word_next.last     = (value_reg == '0);
                    write_pos_next         = POS_W'(start_reg) + POS_W'(cnt_reg);
                    remaining_next         = value_reg;
                    if (value_reg == '0)
                        state_next = S_IDLE;
                    else
                    begin
                        div_req.start = 1'b1;
                        state_next    = S_DIGIT;
                    end
                end
            end
            S_DIGIT:
            begin
                if (div_stat.done)
                begin
                    digit_next     = div_stat.remainder;
                    remaining_next = div_quot;
                    state_next     = S_EMIT;
                end
            end
            S_EMIT:
            begin
                // digits come out least significant first at falling positions
                if (out_free)
                begin
                    res_valid_next         = 1'b1;
                    res_word_next.symbol   = digit_sym;
                    res_word_next.position = write_pos_reg - POS_W'(1);
                    res_word_next.last     = (remaining_reg == '0);
                    write_pos_next         = write_pos_reg - POS_W'(1);
                    if (remaining_reg == '0)
                        state_next = S_IDLE;
                    else
                    begin
                        div_req.start = 1'b1;
                        state_next    = S_DIGIT;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    rde_div_unit u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .dividend (remaining_next),
        .stat     (div_stat),
        .quotient (div_quot)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            res_valid_reg <= 1'b0;
            base_len_reg  <= BASE_LEN_RESET;
            alpha_lo_reg  <= '0;
            alpha_hi_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
            // unknown register indexes are ignored
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_BASE_LEN:      base_len_reg <= cfg_data[RADIX_W-1:0];
                    REG_ALPHABET_LOW:  alpha_lo_reg <= cfg_data;
                    REG_ALPHABET_HIGH: alpha_hi_reg <= cfg_data;
                    default:           ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg     <= value_next;
        start_reg     <= start_next;
        remaining_reg <= remaining_next;
        cnt_reg       <= cnt_next;
        write_pos_reg <= write_pos_next;
        digit_reg     <= digit_next;
        res_word_reg  <= res_word_next;
    end

    // the item side is open only between conversions
    assign item_stall   = (state_reg != S_IDLE);
    assign result_valid = res_valid_reg;
    assign result       = res_word_reg;

endmodule

// ===== rtl/core/rde_checker.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rde_checker
    import rde_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    item_valid,
    input logic    item_stall,
    input item_t   item,
    input logic    result_valid,
    input logic    result_stall,
    input result_t result
);

    // a stalled result word holds
    `ASSERT_CLK(a_result_hold, result_valid && result_stall |=> result_valid && $stable(result), "stalled result changed")

    // an accepted item keeps the block busy on the next cycle
    `ASSERT_CLK(a_busy_after_take, item_valid && !item_stall |=> item_stall, "item side open right after a take")

    // while a conversion still has words to give, no new item is taken
    `ASSERT_NEVER(a_no_take_midway, result_valid && !result.last && !item_stall, "item side open mid conversion")

    // position zero is only ever the final word of a conversion
    `ASSERT_NEVER(a_pos0_last, result_valid && result.position == '0 && !result.last, "word at position zero not final")

endmodule

bind radix_digit_emitter rde_checker u_rde_checker (.*);
